// ----- hw/rtl/dash_pkg.sv -----
// Package for the debounced arcade stick HID report block.
// Payload and queue types, config bundle, codes and constants.
// No dependencies; imported by every RTL module of the block.
package dash_pkg;

  localparam int unsigned ATTACK_BUTTONS = 8;
  localparam int unsigned NBTN           = 17;
  localparam int unsigned SYS_BUTTONS    = 5;
  localparam int unsigned HOLD_W         = 18;   // 255 * 1000 fits
  localparam int unsigned MS_TO_US       = 1000;
  localparam int unsigned QDEPTH         = 4;
  localparam int unsigned QPTR_W         = 2;

  // Button index positions in the level vectors
  localparam int unsigned BTN_UP     = 0;
  localparam int unsigned BTN_DOWN   = 1;
  localparam int unsigned BTN_LEFT   = 2;
  localparam int unsigned BTN_RIGHT  = 3;
  localparam int unsigned BTN_ATTACK = 4;
  localparam int unsigned BTN_SYS    = 12;

  localparam logic [7:0] ATTACK_MASK = 8'((9'd1 << ATTACK_BUTTONS) - 9'd1);

  // Configuration register indexes
  localparam logic [1:0] CFG_HOLD_MS      = 2'd0;
  localparam logic [1:0] CFG_DEFAULT_MODE = 2'd1;
  localparam logic [1:0] CFG_SWITCHES     = 2'd2;
  localparam logic [1:0] CFG_PRESENT      = 2'd3;

  // Stick modes; the unused code behaves as right stick
  localparam logic [1:0] MODE_DPAD  = 2'd0;
  localparam logic [1:0] MODE_LEFT  = 2'd1;
  localparam logic [1:0] MODE_RIGHT = 2'd2;

  // Hat codes
  localparam logic [3:0] HAT_UP         = 4'd0;
  localparam logic [3:0] HAT_UP_RIGHT   = 4'd1;
  localparam logic [3:0] HAT_RIGHT      = 4'd2;
  localparam logic [3:0] HAT_DOWN_RIGHT = 4'd3;
  localparam logic [3:0] HAT_DOWN       = 4'd4;
  localparam logic [3:0] HAT_DOWN_LEFT  = 4'd5;
  localparam logic [3:0] HAT_LEFT       = 4'd6;
  localparam logic [3:0] HAT_UP_LEFT    = 4'd7;
  localparam logic [3:0] HAT_CENTRED    = 4'd8;

  localparam logic signed [7:0] AXIS_POS  = 8'sd127;
  localparam logic signed [7:0] AXIS_NEG  = -8'sd127;
  localparam logic signed [7:0] AXIS_ZERO = 8'sd0;

  typedef struct packed {
    logic        dir_up;
    logic        dir_down;
    logic        dir_left;
    logic        dir_right;
    logic [7:0]  attack_buttons;
    logic [4:0]  system_buttons;
    logic        mode_a;
    logic        mode_b;
    logic [31:0] now_us;
    logic        host_ready;
  } in_item_t;

  typedef struct packed {
    logic [12:0]       report_buttons;
    logic [3:0]        hat;
    logic signed [7:0] axis_x;
    logic signed [7:0] axis_y;
    logic signed [7:0] axis_z;
    logic signed [7:0] axis_rz;
  } out_report_t;

  typedef struct packed {
    logic [HOLD_W-1:0] hold_us;
    logic [1:0]        default_mode;
    logic              switches_present;
    logic [NBTN-1:0]   present;
  } dash_cfg_t;

  // One classified poll, passed from the front to the back
  typedef struct packed {
    logic [NBTN-1:0] stable;
    logic [1:0]      mode;
    logic            host_ready;
  } dash_entry_t;

endpackage

// ----- hw/rtl/debounced_arcade_stick_hid_report.sv -----
// Top level of the debounced arcade stick HID report block.
// Depends on dash_pkg, dash_front, dash_queue and dash_back.
//
//   port group  | direction | handshake            | payload
//   ------------+-----------+----------------------+-----------------------------
//   in_*        | in        | in_valid / in_ready  | in_data   (in_item_t, poll)
//   out_*       | out       | out_valid / out_ready| out_data  (out_report_t)
//   cfg_*       | in        | cfg_we, no wait      | cfg_index, cfg_wdata
//
// Rate: one poll per cycle while the queue is not full. A poll accepted at an
// edge updates the debouncers and is written into the queue at that edge; the
// back part then loads the report built from the queue head into the output register.
// Reset (synchronous, rst_n low) clears debouncer state, queue, output valid
// flag and last sent report; there is no clearing pass.
// Stalls: a 4-entry queue absorbs output back-pressure; in_ready drops only
// while the queue is full. Polls that repeat the last report pass through
// the back part without touching the output register.
module debounced_arcade_stick_hid_report import dash_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_report_t out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_wdata
);

  dash_cfg_t   cfg_r;
  logic        q_push, q_full, q_pop, q_head_valid;
  dash_entry_t q_push_data, q_head;

  // Configuration: the hold time is kept in microseconds so the debouncers
  // see a ready-made threshold.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_us          <= HOLD_W'(5 * MS_TO_US);
      cfg_r.default_mode     <= MODE_DPAD;
      cfg_r.switches_present <= 1'b0;
      cfg_r.present          <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HOLD_MS:      cfg_r.hold_us <= HOLD_W'(cfg_wdata[7:0]) * HOLD_W'(MS_TO_US);
        CFG_DEFAULT_MODE: cfg_r.default_mode <= cfg_wdata[1:0];
        CFG_SWITCHES:     cfg_r.switches_present <= cfg_wdata[0];
        CFG_PRESENT:      cfg_r.present <= cfg_wdata[NBTN-1:0];
        default: ;
      endcase
    end
  end

  // Front: debounce and classify each poll
  dash_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_push_data)
  );

  // Decouple front from output stalls
  dash_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // Back: build report, drop repeats, drive the output register
  dash_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ----- hw/rtl/dash_front.sv -----
// Front part: masks raw levels, runs the 17 debouncers, picks the stick mode.
// Depends on dash_pkg; pushes one dash_entry_t per accepted poll.
module dash_front import dash_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  input  dash_cfg_t   cfg,
  input  logic        q_full,
  output logic        q_push,
  output dash_entry_t q_data
);

  logic [NBTN-1:0] raw;
  logic [NBTN-1:0] raw_levels_r, raw_levels_nxt;
  logic [NBTN-1:0] stable_r, stable_nxt;
  logic [31:0]     change_r [NBTN];
  logic [31:0]     change_nxt [NBTN];
  logic [1:0]      mode;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    raw = {in_data.system_buttons, in_data.attack_buttons & ATTACK_MASK,
           in_data.dir_right, in_data.dir_left, in_data.dir_down, in_data.dir_up};
    raw = raw & cfg.present;
  end

  // Independent per-button debouncers
  always_comb begin
    logic [31:0] age;
    raw_levels_nxt = raw_levels_r;
    stable_nxt     = stable_r;
    age            = '0;
    for (int i = 0; i < NBTN; i++) begin
      change_nxt[i] = change_r[i];
      age = in_data.now_us - change_r[i];
      if (raw[i] != raw_levels_r[i]) begin
        raw_levels_nxt[i] = raw[i];
        change_nxt[i]     = in_data.now_us;
      end else if (raw[i] != stable_r[i] && age >= 32'(cfg.hold_us)) begin
        stable_nxt[i] = raw[i];
      end
    end
  end

  always_comb begin
    mode = cfg.default_mode;
    if (cfg.switches_present) begin
      unique case ({in_data.mode_a, in_data.mode_b})
        2'b00:   mode = MODE_DPAD;
        2'b10:   mode = MODE_LEFT;
        2'b01:   mode = MODE_RIGHT;
        default: mode = cfg.default_mode;
      endcase
    end
  end

  assign q_data = '{stable: stable_nxt, mode: mode, host_ready: in_data.host_ready};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_levels_r <= '0;
      stable_r     <= '0;
      for (int i = 0; i < NBTN; i++) change_r[i] <= '0;
    end else if (q_push) begin
      raw_levels_r <= raw_levels_nxt;
      stable_r     <= stable_nxt;
      for (int i = 0; i < NBTN; i++) change_r[i] <= change_nxt[i];
    end
  end

endmodule

// ----- hw/rtl/dash_queue.sv -----
// Short register queue between front and back.
// Depends on dash_pkg for the entry type and depth.
module dash_queue import dash_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  dash_entry_t push_data,
  output logic        full,
  input  logic        pop,
  output logic        head_valid,
  output dash_entry_t head
);

  dash_entry_t       mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full       = (count_r == (QPTR_W+1)'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- hw/rtl/dash_back.sv -----
// Back part: builds the HID report, drops repeats, holds the output register.
// Depends on dash_pkg; reads the queue head and owns the last sent report.
module dash_back import dash_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  dash_entry_t head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output out_report_t out_data
);

  out_report_t rep;
  out_report_t last_sent_r;
  out_report_t out_data_r;
  logic        out_valid_r;
  logic        u, d, l, r;
  logic        send, can_load;

  function automatic logic [3:0] pick_hat(logic up, logic dn, logic lf, logic rt);
    logic [3:0] h;
    if (up)      h = rt ? HAT_UP_RIGHT : (lf ? HAT_UP_LEFT : HAT_UP);
    else if (dn) h = rt ? HAT_DOWN_RIGHT : (lf ? HAT_DOWN_LEFT : HAT_DOWN);
    else if (rt) h = HAT_RIGHT;
    else if (lf) h = HAT_LEFT;
    else         h = HAT_CENTRED;
    return h;
  endfunction

  function automatic logic signed [7:0] axis_of(logic neg, logic pos);
    logic signed [7:0] a;
    if (neg == pos) a = AXIS_ZERO;
    else            a = pos ? AXIS_POS : AXIS_NEG;
    return a;
  endfunction

  // Opposing directions cancel
  assign u = head.stable[BTN_UP] && !head.stable[BTN_DOWN];
  assign d = head.stable[BTN_DOWN] && !head.stable[BTN_UP];
  assign l = head.stable[BTN_LEFT] && !head.stable[BTN_RIGHT];
  assign r = head.stable[BTN_RIGHT] && !head.stable[BTN_LEFT];

  always_comb begin
    rep = '0;
    rep.report_buttons = {head.stable[BTN_SYS +: SYS_BUTTONS],
                          head.stable[BTN_ATTACK +: 8] & ATTACK_MASK};
    rep.hat = HAT_CENTRED;
    priority if (head.mode == MODE_DPAD) begin
      rep.hat = pick_hat(u, d, l, r);
    end else if (head.mode == MODE_LEFT) begin
      rep.axis_x = axis_of(l, r);
      rep.axis_y = axis_of(u, d);
    end else begin
      rep.axis_z  = axis_of(l, r);
      rep.axis_rz = axis_of(u, d);
    end
  end

  assign send     = head_valid && head.host_ready && (rep != last_sent_r);
  assign can_load = !out_valid_r || out_ready;
  // Hold the head only while a new report waits for the output register
  assign pop      = head_valid && (!send || can_load);

  always_ff @(posedge clk) begin
    if (send && can_load) out_data_r <= rep;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_sent_r <= '0;
    end else begin
      if (send && can_load) begin
        out_valid_r <= 1'b1;
        last_sent_r <= rep;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hw/rtl/dash_checker.sv -----
// Port-level checks for the debounced arcade stick HID report block.
// Depends on dash_pkg; bound to the top level at the end of this file.
module dash_checker import dash_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input out_report_t out_data
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Hold a stalled report
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled report changed");

  // A hat direction excludes any axis deflection
  a_hat_axes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hat != HAT_CENTRED |->
      out_data.axis_x == AXIS_ZERO && out_data.axis_y == AXIS_ZERO &&
      out_data.axis_z == AXIS_ZERO && out_data.axis_rz == AXIS_ZERO)
    else $error("hat and axes both active");

  // Only one stick is driven at a time
  a_one_stick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_data.axis_x == AXIS_ZERO && out_data.axis_y == AXIS_ZERO) ||
      (out_data.axis_z == AXIS_ZERO && out_data.axis_rz == AXIS_ZERO))
    else $error("both sticks driven");

  // Hat code stays in range
  a_hat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.hat <= HAT_CENTRED)
    else $error("hat code out of range");

endmodule

bind debounced_arcade_stick_hid_report dash_checker u_dash_checker (.*);
